// ----- src/mclp_pkg.sv -----
package mclp_pkg;

    localparam int LINE_BYTES_DEF  = 32;
    localparam int MOTOR_COUNT_DEF = 4;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_S     = 8'h53;

    // result status codes
    localparam logic [2:0] ST_APPLIED   = 3'd0;
    localparam logic [2:0] ST_UNCHANGED = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_OFF       = 3'd4;
    localparam logic [2:0] ST_RXERR     = 3'd5;

    // motor directions
    localparam logic [1:0] DIR_FWD  = 2'd0;
    localparam logic [1:0] DIR_REV  = 2'd1;
    localparam logic [1:0] DIR_HALT = 2'd2;

    localparam logic [7:0] SPEED_CAP = 8'd255;
    localparam logic [6:0] DUTY_MAX  = 7'd100;

    typedef struct packed {
        logic       off_hit;  // line is exactly "OFF"
        logic       cmd_ok;   // well-formed speed command with a legal speed
        logic [7:0] speed;    // saturated speed magnitude
    } scan_res_t;

endpackage

// ----- src/mclp_scan.sv -----
module mclp_scan #(
    parameter int MOTOR_COUNT = mclp_pkg::MOTOR_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      step,
    input  logic [7:0]                char_in,
    output mclp_pkg::scan_res_t       res,
    output logic [2*MOTOR_COUNT-1:0]  dirs
);
    import mclp_pkg::*;

    localparam int MW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_WS     = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_DIGS   = 3'd3;
    localparam logic [2:0] PH_DLET   = 3'd4;
    localparam logic [2:0] PH_DCHR   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_BAD    = 3'd7;

    logic [2:0]    phase_reg, phase_next;
    logic [7:0]    mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [MW-1:0] motor_reg, motor_next;
    logic [2:0]    idx_reg;
    logic          off_reg;
    logic [1:0]    dir_reg [MOTOR_COUNT];
    logic          dir_we;

    logic          is_digit;
    logic          is_space;
    logic [11:0]   mag_prod;

    assign is_digit = char_in inside {[CH_ZERO:CH_NINE]};
    assign is_space = (char_in == CH_SPACE) || (char_in inside {[CH_TAB:CH_CR]});
    assign mag_prod = {4'd0, mag_reg} * 12'd10 + {8'd0, char_in[3:0]};

    always_comb
    begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        motor_next = motor_reg;
        dir_we     = 1'b0;
        case (phase_reg)
            PH_FIRST:
            begin
                phase_next = (char_in == CH_S) ? PH_WS : PH_BAD;
            end
            PH_WS:
            begin
                if (is_space)
                begin
                    phase_next = PH_WS;
                end
                else if (char_in == CH_PLUS || char_in == CH_MINUS)
                begin
                    neg_next   = (char_in == CH_MINUS);
                    phase_next = PH_SIGNED;
                end
                else if (is_digit)
                begin
                    mag_next   = {4'd0, char_in[3:0]};
                    phase_next = PH_DIGS;
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            PH_SIGNED:
            begin
                if (is_digit)
                begin
                    mag_next   = {4'd0, char_in[3:0]};
                    phase_next = PH_DIGS;
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            PH_DIGS:
            begin
                if (is_digit)
                begin
                    // saturate the magnitude
                    mag_next = (mag_prod > {4'd0, SPEED_CAP}) ? SPEED_CAP : mag_prod[7:0];
                end
                else if (char_in == CH_D)
                begin
                    phase_next = PH_DCHR;
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            PH_DLET:
            begin
                phase_next = (char_in == CH_D) ? PH_DCHR : PH_BAD;
            end
            PH_DCHR:
            begin
                if (char_in inside {[CH_ZERO:CH_TWO]})
                begin
                    dir_we = 1'b1;
                    if (motor_reg == MW'(MOTOR_COUNT - 1))
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        motor_next = motor_reg + MW'(1);
                        phase_next = PH_DLET;
                    end
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            neg_reg   <= 1'b0;
            motor_reg <= '0;
            idx_reg   <= '0;
            off_reg   <= 1'b0;
        end
        else if (start)
        begin
            phase_reg <= PH_FIRST;
            neg_reg   <= 1'b0;
            motor_reg <= '0;
            idx_reg   <= '0;
            off_reg   <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            motor_reg <= motor_next;
            if (idx_reg != 3'd4)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            // "OFF" must match exactly, with nothing after it
            case (idx_reg)
                3'd0:    off_reg <= off_reg && (char_in == CH_O);
                3'd1:    off_reg <= off_reg && (char_in == CH_F);
                3'd2:    off_reg <= off_reg && (char_in == CH_F);
                default: off_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= '0;
        end
        else if (step)
        begin
            mag_reg <= mag_next;
            if (dir_we)
            begin
                dir_reg[motor_reg] <= char_in[1:0];
            end
        end
    end

    for (genvar k = 0; k < MOTOR_COUNT; k++)
    begin : g_dirs
        assign dirs[2*k +: 2] = dir_reg[k];
    end

    assign res.off_hit = off_reg && (idx_reg == 3'd3);
    assign res.cmd_ok  = (phase_reg == PH_DONE) && !(neg_reg && mag_reg != 8'd0);
    assign res.speed   = mag_reg;

endmodule

// ----- src/motor_command_line_parser_unit.sv -----
// Channel | Direction | Handshake          | Word
// --------+-----------+--------------------+------------------------------------
// in      | in        | in_valid, in_stall | action, rx_byte
// out     | out       | out_valid,out_stall| status, pwm_on, duty, drive_pins
//
// A byte that neither ends a line nor overflows it is taken and the input stays open.
// A line feed walks the stored line one byte a cycle through the line store
// read port: the input stalls through the scan and while the result loads.
// Overflow and timeout words stall the input while their result loads.
// The input also stalls while a finished word waits on a stalled output.
// Reset needs no clearing pass: the line store is only used where written.
module motor_command_line_parser_unit #(
    parameter int LINE_BYTES  = mclp_pkg::LINE_BYTES_DEF,
    parameter int MOTOR_COUNT = mclp_pkg::MOTOR_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic       pwm_on,
    output logic [6:0] duty,
    output logic [7:0] drive_pins
);
    import mclp_pkg::*;

    localparam int AW = $clog2(LINE_BYTES);
    localparam int PM = (MOTOR_COUNT < 4) ? MOTOR_COUNT : 4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [7:0]               mem [LINE_BYTES];
    logic [7:0]               rd_data_reg;
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;

    logic [1:0]               state_reg;
    logic [AW-1:0]            fill_reg;
    logic                     prev_cr_reg;
    logic [AW-1:0]            len_reg;
    logic [AW-1:0]            pos_reg;
    logic [2:0]               res_status_reg;

    logic                     known_reg;
    logic [6:0]               speed_reg;
    logic [2*MOTOR_COUNT-1:0] dirs_reg;
    logic                     pwm_reg;
    logic [6:0]               duty_reg;
    logic [7:0]               pins_reg;

    logic                     out_valid_reg;
    logic [2:0]               status_reg;
    logic                     pwm_out_reg;
    logic [6:0]               duty_out_reg;
    logic [7:0]               pins_out_reg;

    logic                     in_take;
    logic                     is_lf;
    logic [AW:0]              fill_inc;
    logic                     at_end;
    logic                     scan_start;
    logic                     scan_step;
    logic                     load_ok;
    logic                     changed;
    logic [6:0]               clamped;
    logic [7:0]               apply_pins;

    scan_res_t                scan_res;
    logic [2*MOTOR_COUNT-1:0] scan_dirs;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign is_lf      = (rx_byte == CH_LF);
    assign fill_inc   = {1'b0, fill_reg} + (AW+1)'(1);
    assign mem_we     = in_take && !action && !is_lf;
    assign scan_start = in_take && !action && is_lf;
    assign at_end     = (pos_reg == len_reg) || (rd_data_reg == CH_NUL);
    assign scan_step  = (state_reg == S_SCAN) && !at_end;
    assign load_ok    = !out_valid_reg || !out_stall;
    assign rd_addr    = (state_reg == S_SCAN && pos_reg != len_reg) ?
                        pos_reg + AW'(1) : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[fill_reg] <= rx_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    mclp_scan #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .step    (scan_step),
        .char_in (rd_data_reg),
        .res     (scan_res),
        .dirs    (scan_dirs)
    );

    assign clamped = (scan_res.speed > {1'b0, DUTY_MAX}) ? DUTY_MAX : scan_res.speed[6:0];
    assign changed = !known_reg || ({1'b0, speed_reg} != scan_res.speed) ||
                     (dirs_reg != scan_dirs);

    // pin codes: forward 01, reverse 10, stop 00
    always_comb
    begin
        apply_pins = pins_reg;
        for (int k = 0; k < PM; k++)
        begin
            case (scan_dirs[2*k +: 2])
                DIR_FWD: apply_pins[2*k +: 2] = 2'b01;
                DIR_REV: apply_pins[2*k +: 2] = 2'b10;
                default: apply_pins[2*k +: 2] = 2'b00;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            prev_cr_reg    <= 1'b0;
            len_reg        <= '0;
            pos_reg        <= '0;
            res_status_reg <= ST_APPLIED;
            known_reg      <= 1'b0;
            speed_reg      <= '0;
            dirs_reg       <= '0;
            pwm_reg        <= 1'b0;
            duty_reg       <= '0;
            pins_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        if (action)
                        begin
                            // timeout: drop the partial line and stop everything
                            fill_reg       <= '0;
                            prev_cr_reg    <= 1'b0;
                            pwm_reg        <= 1'b0;
                            known_reg      <= 1'b1;
                            speed_reg      <= '0;
                            dirs_reg       <= {MOTOR_COUNT{DIR_HALT}};
                            pins_reg       <= '0;
                            res_status_reg <= ST_RXERR;
                            state_reg      <= S_EMIT;
                        end
                        else if (is_lf)
                        begin
                            len_reg     <= (fill_reg != '0 && prev_cr_reg) ?
                                           fill_reg - AW'(1) : fill_reg;
                            pos_reg     <= '0;
                            fill_reg    <= '0;
                            prev_cr_reg <= 1'b0;
                            state_reg   <= S_SCAN;
                        end
                        else if (fill_inc == (AW+1)'(LINE_BYTES))
                        begin
                            fill_reg       <= '0;
                            prev_cr_reg    <= 1'b0;
                            res_status_reg <= ST_OVERFLOW;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            fill_reg    <= fill_inc[AW-1:0];
                            prev_cr_reg <= (rx_byte == CH_CR);
                        end
                    end
                end
                S_SCAN:
                begin
                    if (!at_end)
                    begin
                        pos_reg <= pos_reg + AW'(1);
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                        if (scan_res.off_hit)
                        begin
                            pwm_reg        <= 1'b0;
                            known_reg      <= 1'b1;
                            speed_reg      <= '0;
                            dirs_reg       <= {MOTOR_COUNT{DIR_HALT}};
                            pins_reg       <= '0;
                            res_status_reg <= ST_OFF;
                        end
                        else if (!scan_res.cmd_ok)
                        begin
                            res_status_reg <= ST_INVALID;
                        end
                        else if (!changed)
                        begin
                            res_status_reg <= ST_UNCHANGED;
                        end
                        else
                        begin
                            known_reg      <= 1'b1;
                            speed_reg      <= clamped;
                            dirs_reg       <= scan_dirs;
                            pins_reg       <= apply_pins;
                            pwm_reg        <= (clamped != '0);
                            if (clamped != '0)
                            begin
                                duty_reg <= clamped;
                            end
                            res_status_reg <= ST_APPLIED;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (load_ok)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_EMIT && load_ok)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT && load_ok)
        begin
            status_reg   <= res_status_reg;
            pwm_out_reg  <= pwm_reg;
            duty_out_reg <= duty_reg;
            pins_out_reg <= pins_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign pwm_on     = pwm_out_reg;
    assign duty       = duty_out_reg;
    assign drive_pins = pins_out_reg;

`ifndef SYNTH
    a_pwm_duty: assert property (@(posedge clk) disable iff (!rst_n)
        pwm_reg |-> duty_reg != '0)
        else $error("pwm running with zero duty");

    a_stop_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OFF || status == ST_RXERR) |->
            !pwm_on && drive_pins == 8'd0)
        else $error("stop word with motors still driven");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= AW'(LINE_BYTES - 1))
        else $error("fill count past line length");

    a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> pos_reg <= len_reg)
        else $error("scan position past line end");

    a_lf_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && !action && is_lf |=> state_reg == S_SCAN && pos_reg == '0)
        else $error("line feed did not start a scan");
`endif

endmodule

// ----- test/tb_motor_command_line_parser_unit.sv -----
module tb_motor_command_line_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mclp_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_WORDS = 260;
    localparam int RANDOM_LINES = 16;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    typedef struct packed {
        logic       act;
        logic [7:0] b;
    } rx_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic       pwm_on;
        logic [6:0] duty;
        logic [7:0] pins;
    } motor_word_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       action = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] status;
    logic       pwm_on;
    logic [6:0] duty;
    logic [7:0] drive_pins;

    rx_word_t    rx_words_todo[$];
    motor_word_t motor_words_due[$];
    logic [7:0]  scratch[$];

    // parser state as the block should hold it
    logic [7:0] line_buf [LINE_BYTES_DEF];
    int         fill_cnt = 0;
    bit         last_cr = 1'b0;
    int         cur_speed = -1;
    logic [1:0] cur_dirs [MOTOR_COUNT_DEF] = '{default: DIR_FWD};
    bit         pwm_run = 1'b0;
    logic [6:0] duty_pct = 7'd0;
    logic [7:0] pin_bits = 8'h00;

    int  words_in = 0;
    int  words_out = 0;
    int  errors = 0;
    int  cycle_count = 0;
    int  status_seen [8] = '{default: 0};
    int  gap_left = 0;
    int  stall_left = 0;
    int  mode_left = 0;
    bit  quiet_tx = 1'b0;
    bit  quiet_rx = 1'b0;
    bit  hold_rx = 1'b0;

    motor_command_line_parser_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .pwm_on     (pwm_on),
        .duty       (duty),
        .drive_pins (drive_pins)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void set_motor(int k, logic [1:0] dir);
        cur_dirs[k] = dir;
        if (k < 4)
        begin
            pin_bits[2*k +: 2] = (dir == DIR_FWD) ? 2'b01 : (dir == DIR_REV) ? 2'b10 : 2'b00;
        end
    endfunction

    function automatic void stop_motors();
        pwm_run = 1'b0;
        cur_speed = 0;
        for (int k = 0; k < MOTOR_COUNT_DEF; k++)
            set_motor(k, DIR_HALT);
    endfunction

    function automatic void predict_motor_word(logic act, logic [7:0] b);
        int         len;
        int         pos;
        int         mag;
        int         ndig;
        bit         neg;
        bit         ok;
        bit         changed;
        bit         hit;
        logic [2:0] st;
        logic [1:0] dirs [MOTOR_COUNT_DEF];
        hit = 1'b1;
        st = ST_INVALID;
        if (act)
        begin
            fill_cnt = 0;
            last_cr = 1'b0;
            stop_motors();
            st = ST_RXERR;
        end
        else if (b == CH_LF)
        begin
            len = fill_cnt;
            if (len > 0 && last_cr)
                len--;
            // cut the line at its first zero byte
            for (int k = 0; k < len; k++)
            begin
                if (line_buf[k] == CH_NUL)
                begin
                    len = k;
                    break;
                end
            end
            fill_cnt = 0;
            last_cr = 1'b0;
            if (len == 3 && line_buf[0] == CH_O && line_buf[1] == CH_F && line_buf[2] == CH_F)
            begin
                stop_motors();
                st = ST_OFF;
            end
            else if (len > 0 && line_buf[0] == CH_S)
            begin
                pos = 1;
                while (pos < len && (line_buf[pos] == CH_SPACE ||
                       (line_buf[pos] >= CH_TAB && line_buf[pos] <= CH_CR)))
                    pos++;
                neg = 1'b0;
                if (pos < len && (line_buf[pos] == CH_PLUS || line_buf[pos] == CH_MINUS))
                begin
                    neg = (line_buf[pos] == CH_MINUS);
                    pos++;
                end
                mag = 0;
                ndig = 0;
                while (pos < len && line_buf[pos] >= CH_ZERO && line_buf[pos] <= CH_NINE)
                begin
                    mag = mag * 10 + (int'(line_buf[pos]) - int'(CH_ZERO));
                    if (mag > int'(SPEED_CAP))
                        mag = int'(SPEED_CAP);
                    ndig++;
                    pos++;
                end
                ok = (ndig > 0);
                for (int k = 0; k < MOTOR_COUNT_DEF && ok; k++)
                begin
                    if (pos + 1 >= len || line_buf[pos] != CH_D)
                        ok = 1'b0;
                    else if (line_buf[pos+1] < CH_ZERO || line_buf[pos+1] > CH_TWO)
                        ok = 1'b0;
                    else
                    begin
                        dirs[k] = 2'(line_buf[pos+1] - CH_ZERO);
                        pos += 2;
                    end
                end
                if (ok && !(neg && mag > 0))
                begin
                    changed = (cur_speed < 0) || (cur_speed != mag);
                    for (int k = 0; k < MOTOR_COUNT_DEF; k++)
                        if (dirs[k] != cur_dirs[k])
                            changed = 1'b1;
                    if (!changed)
                        st = ST_UNCHANGED;
                    else
                    begin
                        pwm_run = 1'b0;
                        for (int k = 0; k < MOTOR_COUNT_DEF; k++)
                            set_motor(k, dirs[k]);
                        // store the clamped speed, so a repeat of a big speed still applies
                        if (mag > int'(DUTY_MAX))
                            mag = int'(DUTY_MAX);
                        if (mag > 0)
                        begin
                            duty_pct = 7'(mag);
                            pwm_run = 1'b1;
                        end
                        cur_speed = mag;
                        st = ST_APPLIED;
                    end
                end
            end
        end
        else
        begin
            line_buf[fill_cnt] = b;
            fill_cnt++;
            last_cr = (b == CH_CR);
            if (fill_cnt >= LINE_BYTES_DEF)
            begin
                fill_cnt = 0;
                last_cr = 1'b0;
                st = ST_OVERFLOW;
            end
            else
                hit = 1'b0;
        end
        if (hit)
            motor_words_due.push_back('{st, pwm_run, duty_pct, pin_bits});
    endfunction

    function automatic int idle_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            scratch.push_back(s[i]);
    endtask

    task automatic flush_scratch(bit add_cr, bit add_lf);
        foreach (scratch[i])
            rx_words_todo.push_back('{1'b0, scratch[i]});
        if (add_cr)
            rx_words_todo.push_back('{1'b0, CH_CR});
        if (add_lf)
            rx_words_todo.push_back('{1'b0, CH_LF});
        scratch.delete();
    endtask

    task automatic send_line(string s, bit add_cr);
        add_text(s);
        flush_scratch(add_cr, 1'b1);
    endtask

    task automatic push_timeout(logic [7:0] junk);
        rx_words_todo.push_back('{1'b1, junk});
    endtask

    // speed command, mostly well-formed, with random content in scratch
    task automatic build_speed_cmd();
        int n;
        int v;
        scratch.delete();
        scratch.push_back(CH_S);
        if ($urandom_range(0, 9) >= 7)
        begin
            repeat ($urandom_range(1, 2))
            begin
                n = $urandom_range(0, 4);
                scratch.push_back(n == 0 ? CH_SPACE : n == 1 ? CH_TAB :
                                  n == 2 ? CH_VT : n == 3 ? CH_FF : CH_CR);
            end
        end
        n = $urandom_range(0, 9);
        if (n == 0)
            scratch.push_back(CH_MINUS);
        else if (n == 1)
            scratch.push_back(CH_PLUS);
        n = $urandom_range(0, 9);
        v = (n < 4) ? $urandom_range(0, 9) :
            (n < 6) ? $urandom_range(95, 105) :
            (n < 7) ? $urandom_range(250, 260) :
            (n < 8) ? $urandom_range(0, 100000) : $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0)
            add_text("00");
        add_text($sformatf("%0d", v));
        for (int k = 0; k < MOTOR_COUNT_DEF; k++)
        begin
            scratch.push_back(CH_D);
            if ($urandom_range(0, 99) < 92)
                scratch.push_back(CH_ZERO + 8'($urandom_range(0, 2)));
            else
                scratch.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3))
                scratch.push_back(8'($urandom_range(8'h21, 8'h7E)));
    endtask

    // leave some stretches with no idling at all
    always @(posedge clk)
    begin : pacing
        if (mode_left == 0)
        begin
            quiet_tx <= ($urandom_range(0, 3) == 0);
            quiet_rx <= ($urandom_range(0, 3) == 0);
            mode_left <= $urandom_range(100, 400);
        end
        else
            mode_left <= mode_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin : driver
        rx_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= 1'b0;
            rx_byte <= 8'h00;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_motor_word(action, rx_byte);
                words_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (rx_words_todo.size() > 0)
                begin
                    w = rx_words_todo.pop_front();
                    in_valid <= 1'b1;
                    action <= w.act;
                    rx_byte <= w.b;
                    gap_left <= idle_len(quiet_tx);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        motor_word_t exp_w;
        int          n;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                words_out++;
                status_seen[status]++;
                if (motor_words_due.size() == 0)
                begin
                    $error("unexpected word: status %0d pwm_on %0d duty %0d drive_pins %02h",
                           status, pwm_on, duty, drive_pins);
                    errors++;
                end
                else
                begin
                    exp_w = motor_words_due.pop_front();
                    if (status !== exp_w.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", exp_w.status, status);
                        errors++;
                    end
                    if (pwm_on !== exp_w.pwm_on)
                    begin
                        $error("pwm_on mismatch: expected %0d, actual %0d", exp_w.pwm_on, pwm_on);
                        errors++;
                    end
                    if (duty !== exp_w.duty)
                    begin
                        $error("duty mismatch: expected %0d, actual %0d", exp_w.duty, duty);
                        errors++;
                    end
                    if (drive_pins !== exp_w.pins)
                    begin
                        $error("drive_pins mismatch: expected %02h, actual %02h",
                               exp_w.pins, drive_pins);
                        errors++;
                    end
                end
            end
            if (hold_rx)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                n = idle_len(quiet_rx);
                stall_left <= (n > 0) ? n - 1 : 0;
                out_stall <= (n > 0);
            end
        end
    end

    // long receiver hold-off: the block must fill up and stall its input
    initial
    begin : receiver_hold
        wait (words_in >= 300);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout after %0d cycles, %0d words still due", cycle_count,
               motor_words_due.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int         todo_floor;
        int         lines_made;
        int         r;
        int         n;
        logic [7:0] last_cmd[$];

        // directed part
        send_line("S50D0D1D2D0", 1'b0);
        send_line("S50D0D1D2D0", 1'b0);
        scratch.push_back(CH_S);
        scratch.push_back(CH_TAB);
        add_text("+50D0D1D2D0");
        flush_scratch(1'b1, 1'b1);
        send_line("S255D1D1D1D1", 1'b0);
        send_line("S99999D1D1D1D1", 1'b0);
        send_line("S-0D0D0D0D0", 1'b1);
        send_line("S-5D0D0D0D0", 1'b0);
        send_line("S10D0D0D3D0", 1'b0);
        send_line("S10D0D0D0", 1'b0);
        send_line("SD0D0D0D0", 1'b0);
        scratch.push_back(CH_S);
        scratch.push_back(CH_VT);
        scratch.push_back(CH_FF);
        add_text(" 007D2D1D0D1zz");
        flush_scratch(1'b0, 1'b1);
        send_line("OFF", 1'b0);
        send_line("OFF", 1'b1);
        send_line("OFFX", 1'b0);
        send_line("", 1'b0);
        send_line("", 1'b1);
        add_text("OFF");
        scratch.push_back(CH_NUL);
        add_text("S9D0D0D0D0");
        flush_scratch(1'b0, 1'b1);
        scratch.push_back(CH_S);
        scratch.push_back(8'hFF);
        scratch.push_back(8'h80);
        scratch.push_back(8'h7F);
        flush_scratch(1'b0, 1'b1);
        send_line("S70D1D0D1D0", 1'b0);
        add_text("S40D0");
        flush_scratch(1'b0, 1'b0);
        push_timeout(8'hFF);
        push_timeout(CH_LF);
        // longest line that still fits, then one byte more
        add_text("S100D0D0D0D0xxxxxxxxxxxxxxxxxxx");
        flush_scratch(1'b0, 1'b1);
        add_text("S100D0D0D0D0xxxxxxxxxxxxxxxxxxxx");
        flush_scratch(1'b0, 1'b0);
        send_line("1D0D0D0D0", 1'b0);
        add_text("S100D0D0D0D0xxxxxxxxxxxxxxxxxx");
        flush_scratch(1'b1, 1'b1);
        add_text("S100D0D0D0D0xxxxxxxxxxxxxxxxxxx");
        flush_scratch(1'b1, 1'b0);
        flush_scratch(1'b0, 1'b1);

        // random part: mostly commands, with repeats, noise and broken lines
        todo_floor = rx_words_todo.size() + RANDOM_WORDS;
        lines_made = 0;
        while (rx_words_todo.size() < todo_floor || lines_made < RANDOM_LINES)
        begin
            r = $urandom_range(0, 99);
            lines_made++;
            if (r < 15 && last_cmd.size() > 0)
            begin
                scratch = last_cmd;
                flush_scratch($urandom_range(0, 4) == 0, 1'b1);
            end
            else if (r < 60)
            begin
                build_speed_cmd();
                last_cmd = scratch;
                flush_scratch($urandom_range(0, 4) == 0, 1'b1);
            end
            else if (r < 68)
                send_line("OFF", $urandom_range(0, 3) == 0);
            else if (r < 76)
            begin
                repeat ($urandom_range(0, 40))
                    scratch.push_back(8'($urandom_range(0, 255)));
                flush_scratch(1'b0, $urandom_range(0, 3) != 0);
            end
            else if (r < 82)
            begin
                build_speed_cmd();
                n = $urandom_range(0, scratch.size());
                while (scratch.size() > n)
                    void'(scratch.pop_back());
                flush_scratch(1'b0, 1'b0);
                push_timeout(8'($urandom_range(0, 255)));
            end
            else
            begin
                build_speed_cmd();
                n = $urandom_range(0, scratch.size() - 1);
                scratch[n] = $urandom_range(0, 1) ? CH_NUL : 8'($urandom_range(0, 255));
                flush_scratch($urandom_range(0, 4) == 0, 1'b1);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_words_todo.size() > 0 || in_valid)
            @(posedge clk);
        while (motor_words_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input words and %0d result words in %0d cycles, %s %0d cycles",
                 words_in, words_out, cycle_count, "output hold-off of", HOLD_CYCLES);
        $display("results: applied %0d, unchanged %0d, invalid %0d, %s %0d, off %0d, rx error %0d",
                 status_seen[ST_APPLIED], status_seen[ST_UNCHANGED], status_seen[ST_INVALID],
                 "overflow", status_seen[ST_OVERFLOW], status_seen[ST_OFF],
                 status_seen[ST_RXERR]);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
